### rtl/ihx_pkg.sv
package ihx_pkg;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [15:0] MIN_IPV4_FRAME = 16'd34;
  localparam logic [6:0]  ETH_HDR_BYTES  = 7'd14;
  localparam logic [6:0]  TCP_HDR_BYTES  = 7'd20;
  localparam logic [6:0]  UDP_HDR_BYTES  = 7'd8;

  localparam logic [15:0] POS_ETYPE_HI = 16'd12;
  localparam logic [15:0] POS_ETYPE_LO = 16'd13;
  localparam logic [15:0] POS_IHL      = 16'd14;
  localparam logic [15:0] POS_PROTO    = 16'd23;
  localparam logic [15:0] POS_SRC_LO   = 16'd26;
  localparam logic [15:0] POS_SRC_HI   = 16'd29;
  localparam logic [15:0] POS_DST_LO   = 16'd30;
  localparam logic [15:0] POS_DST_HI   = 16'd33;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  localparam logic [1:0] KIND_UNKNOWN = 2'd0;
  localparam logic [1:0] KIND_TCP     = 2'd1;
  localparam logic [1:0] KIND_UDP     = 2'd2;
  localparam logic [1:0] KIND_ICMP    = 2'd3;

  typedef struct packed {
    logic [1:0]  proto_kind;
    logic        addr_valid;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] frame_length;
  } result_t;

endpackage

### rtl/ihx_byte_if.sv
interface ihx_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink (input valid, input frame_byte, input last_byte, output ready);
endinterface

### rtl/ihx_result_if.sv
interface ihx_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  proto_kind;
  logic        addr_valid;
  logic [31:0] src_ip;
  logic [31:0] dst_ip;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic [15:0] frame_length;

  modport source (
    output valid, output proto_kind, output addr_valid, output src_ip, output dst_ip,
    output src_port, output dst_port, output frame_length, input ready
  );
  modport sink (
    input valid, input proto_kind, input addr_valid, input src_ip, input dst_ip,
    input src_port, input dst_port, input frame_length, output ready
  );
endinterface

### rtl/ihx_parser.sv
module ihx_parser
  import ihx_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 65535
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] frame_byte,
  input  logic       last_byte,
  output logic       res_push,
  output result_t    res
);

  localparam logic [15:0] MaxBytes = 16'(MAX_FRAME_BYTES);

  logic [15:0] byte_index, byte_index_next;
  logic [15:0] ether_kind, ether_kind_next;
  logic [3:0]  hdr_words, hdr_words_next;
  logic [7:0]  ip_proto, ip_proto_next;
  logic [31:0] src_addr_reg, src_addr_reg_next;
  logic [31:0] dst_addr_reg, dst_addr_reg_next;
  logic [15:0] sport_reg, sport_reg_next;
  logic [15:0] dport_reg, dport_reg_next;

  logic        cap;
  logic [6:0]  off;
  logic [15:0] off_w;
  logic        ipv4_ok;

  always_comb begin
    cap = byte_index < MaxBytes;

    ether_kind_next   = ether_kind;
    hdr_words_next    = hdr_words;
    ip_proto_next     = ip_proto;
    src_addr_reg_next = src_addr_reg;
    dst_addr_reg_next = dst_addr_reg;
    sport_reg_next    = sport_reg;
    dport_reg_next    = dport_reg;
    byte_index_next   = byte_index;

    if (cap && byte_index == POS_IHL) begin
      hdr_words_next = frame_byte[3:0];
    end
    // port offset follows the header length as updated by this byte
    off   = ETH_HDR_BYTES + {1'b0, hdr_words_next, 2'b00};
    off_w = {9'd0, off};

    if (cap) begin
      byte_index_next = byte_index + 16'd1;
      if (byte_index == POS_ETYPE_HI || byte_index == POS_ETYPE_LO) begin
        ether_kind_next = {ether_kind[7:0], frame_byte};
      end
      if (byte_index == POS_PROTO) begin
        ip_proto_next = frame_byte;
      end
      if (byte_index >= POS_SRC_LO && byte_index <= POS_SRC_HI) begin
        src_addr_reg_next = {src_addr_reg[23:0], frame_byte};
      end
      if (byte_index >= POS_DST_LO && byte_index <= POS_DST_HI) begin
        dst_addr_reg_next = {dst_addr_reg[23:0], frame_byte};
      end
      if (byte_index == off_w || byte_index == off_w + 16'd1) begin
        sport_reg_next = {sport_reg[7:0], frame_byte};
      end
      if (byte_index == off_w + 16'd2 || byte_index == off_w + 16'd3) begin
        dport_reg_next = {dport_reg[7:0], frame_byte};
      end
    end

    ipv4_ok = ether_kind_next == ETHERTYPE_IPV4 && byte_index_next >= MIN_IPV4_FRAME;

    res              = '0;
    res.frame_length = byte_index_next;
    if (ipv4_ok) begin
      res.addr_valid = 1'b1;
      res.src_ip     = src_addr_reg_next;
      res.dst_ip     = dst_addr_reg_next;
      if (ip_proto_next == PROTO_TCP &&
          byte_index_next >= {9'd0, off + TCP_HDR_BYTES}) begin
        res.proto_kind = KIND_TCP;
        res.src_port   = sport_reg_next;
        res.dst_port   = dport_reg_next;
      end else if (ip_proto_next == PROTO_UDP &&
                   byte_index_next >= {9'd0, off + UDP_HDR_BYTES}) begin
        res.proto_kind = KIND_UDP;
        res.src_port   = sport_reg_next;
        res.dst_port   = dport_reg_next;
      end else if (ip_proto_next == PROTO_ICMP) begin
        res.proto_kind = KIND_ICMP;
      end
    end

    res_push = fire && last_byte;
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && last_byte)) begin
      byte_index   <= '0;
      ether_kind   <= '0;
      hdr_words    <= '0;
      ip_proto     <= '0;
      src_addr_reg <= '0;
      dst_addr_reg <= '0;
      sport_reg    <= '0;
      dport_reg    <= '0;
    end else if (fire) begin
      byte_index   <= byte_index_next;
      ether_kind   <= ether_kind_next;
      hdr_words    <= hdr_words_next;
      ip_proto     <= ip_proto_next;
      src_addr_reg <= src_addr_reg_next;
      dst_addr_reg <= dst_addr_reg_next;
      sport_reg    <= sport_reg_next;
      dport_reg    <= dport_reg_next;
    end
  end

endmodule

### rtl/ihx_obuf.sv
module ihx_obuf
  import ihx_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign in_ready = !skid_valid;
  assign pop      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
        out_data  <= push_data;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_valid <= 1'b1;
        out_data  <= push_data;
      end else begin
        skid_valid <= 1'b1;
        skid_data  <= push_data;
      end
    end
  end

endmodule

### rtl/ipv4_l4_header_extractor_top.sv
// channel     dir  payload
// byte_in     in   frame_byte[7:0], last_byte
// result_out  out  proto_kind, addr_valid, src_ip, dst_ip, src_port, dst_port,
//                  frame_length
//
// One byte accepted per cycle while byte_in.ready is high; a frame's result is
// formed combinationally from its last byte and the capture registers, then
// registered into a two-entry result buffer that keeps bytes flowing while a
// result waits; byte_in.ready drops only when both entries are full.
// rst is synchronous and clears the byte counter, captures and the buffer.
module ipv4_l4_header_extractor_top
  import ihx_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 65535
) (
  input logic          clk,
  input logic          rst,
  ihx_byte_if.sink     byte_in,
  ihx_result_if.source result_out
);

  logic    fire;
  logic    res_push;
  result_t res;
  result_t out_data;

  assign fire = byte_in.valid && byte_in.ready;

  ihx_parser #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .frame_byte(byte_in.frame_byte),
    .last_byte (byte_in.last_byte),
    .res_push  (res_push),
    .res       (res)
  );

  ihx_obuf u_obuf (
    .clk      (clk),
    .rst      (rst),
    .push     (res_push),
    .push_data(res),
    .in_ready (byte_in.ready),
    .out_valid(result_out.valid),
    .out_ready(result_out.ready),
    .out_data (out_data)
  );

  assign result_out.proto_kind   = out_data.proto_kind;
  assign result_out.addr_valid   = out_data.addr_valid;
  assign result_out.src_ip       = out_data.src_ip;
  assign result_out.dst_ip       = out_data.dst_ip;
  assign result_out.src_port     = out_data.src_port;
  assign result_out.dst_port     = out_data.dst_port;
  assign result_out.frame_length = out_data.frame_length;

endmodule

### rtl/ihx_checker.sv
module ihx_checker
  import ihx_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        last_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  proto_kind,
  input logic        addr_valid,
  input logic [31:0] src_ip,
  input logic [31:0] dst_ip,
  input logic [15:0] src_port,
  input logic [15:0] dst_port,
  input logic [15:0] frame_length
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(proto_kind) && $stable(src_ip)
      && $stable(dst_ip) && $stable(src_port) && $stable(dst_port)
      && $stable(frame_length))
    else $error("stalled result changed");

  a_last_shows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_byte && !out_valid |=> out_valid)
    else $error("last byte gave no result");

  a_no_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && !addr_valid |-> src_ip == 32'd0 && dst_ip == 32'd0
      && proto_kind == KIND_UNKNOWN && src_port == 16'd0 && dst_port == 16'd0)
    else $error("fields set without valid address");

  a_no_ports: assert property (@(posedge clk) disable iff (rst)
    out_valid && (proto_kind == KIND_UNKNOWN || proto_kind == KIND_ICMP)
      |-> src_port == 16'd0 && dst_port == 16'd0)
    else $error("ports set for non TCP/UDP result");

endmodule

bind ipv4_l4_header_extractor_top ihx_checker u_ihx_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (byte_in.valid),
  .in_ready    (byte_in.ready),
  .last_byte   (byte_in.last_byte),
  .out_valid   (result_out.valid),
  .out_ready   (result_out.ready),
  .proto_kind  (result_out.proto_kind),
  .addr_valid  (result_out.addr_valid),
  .src_ip      (result_out.src_ip),
  .dst_ip      (result_out.dst_ip),
  .src_port    (result_out.src_port),
  .dst_port    (result_out.dst_port),
  .frame_length(result_out.frame_length)
);

### sim/ipv4_l4_header_extractor_top_tb.sv
`timescale 1ns / 100ps

module ipv4_l4_header_extractor_top_tb;
  import ihx_pkg::*;

  localparam int MAX_BYTES = 65535;

  typedef struct packed {
    logic [16:0] len;
    logic [15:0] etype;
    logic [7:0]  ihl_b;
    logic [7:0]  proto;
    logic [7:0]  fill;
    logic        rnd;
    logic        typed;
    result_t     want;
  } frame_row_t;

  // len, ethertype, byte 14, protocol, fill, random fill, typed, expected
  frame_row_t dir_rows [23] = '{
    '{17'd1, 16'h0000, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1,
      '{KIND_UNKNOWN, 1'b0, 32'h0, 32'h0, 16'h0, 16'h0, 16'd1}},
    '{17'd1, 16'h0000, 8'h00, 8'h00, 8'hff, 1'b0, 1'b1,
      '{KIND_UNKNOWN, 1'b0, 32'h0, 32'h0, 16'h0, 16'h0, 16'd1}},
    '{17'd33, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 8'haa, 1'b0, 1'b1,
      '{KIND_UNKNOWN, 1'b0, 32'h0, 32'h0, 16'h0, 16'h0, 16'd33}},
    '{17'd34, ETHERTYPE_IPV4, 8'h45, PROTO_ICMP, 8'h00, 1'b0, 1'b1,
      '{KIND_ICMP, 1'b1, 32'h0, 32'h0, 16'h0, 16'h0, 16'd34}},
    '{17'd60, 16'h86dd, 8'h45, PROTO_TCP, 8'hff, 1'b0, 1'b1,
      '{KIND_UNKNOWN, 1'b0, 32'h0, 32'h0, 16'h0, 16'h0, 16'd60}},
    '{17'd54, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 8'h00, 1'b1, 1'b0, '0},
    '{17'd53, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 8'h00, 1'b1, 1'b0, '0},
    '{17'd42, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 8'h00, 1'b1, 1'b0, '0},
    '{17'd41, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 8'h00, 1'b1, 1'b0, '0},
    '{17'd40, ETHERTYPE_IPV4, 8'h40, PROTO_UDP, 8'h00, 1'b1, 1'b0, '0},
    '{17'd60, ETHERTYPE_IPV4, 8'h41, PROTO_TCP, 8'h00, 1'b1, 1'b0, '0},
    '{17'd60, ETHERTYPE_IPV4, 8'h43, PROTO_UDP, 8'h00, 1'b1, 1'b0, '0},
    '{17'd94, ETHERTYPE_IPV4, 8'h4f, PROTO_TCP, 8'h00, 1'b1, 1'b0, '0},
    '{17'd93, ETHERTYPE_IPV4, 8'h4f, PROTO_TCP, 8'h00, 1'b1, 1'b0, '0},
    '{17'd34, ETHERTYPE_IPV4, 8'h4f, PROTO_ICMP, 8'h00, 1'b1, 1'b0, '0},
    '{17'd64, ETHERTYPE_IPV4, 8'h45, 8'hff, 8'h00, 1'b1, 1'b0, '0},
    '{17'd64, ETHERTYPE_IPV4, 8'hf5, 8'h00, 8'h00, 1'b1, 1'b0, '0},
    '{17'd64, 16'h0801, 8'h45, PROTO_TCP, 8'h00, 1'b1, 1'b0, '0},
    '{17'd64, 16'h0008, 8'h45, PROTO_UDP, 8'h00, 1'b1, 1'b0, '0},
    '{17'd34, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 8'h00, 1'b1, 1'b0, '0},
    '{17'd14, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 8'h00, 1'b1, 1'b0, '0},
    '{17'd65540, 16'hffff, 8'hff, 8'hff, 8'hff, 1'b0, 1'b1,
      '{KIND_UNKNOWN, 1'b0, 32'h0, 32'h0, 16'h0, 16'h0, 16'd65535}},
    '{17'd65535, ETHERTYPE_IPV4, 8'hff, 8'hff, 8'hff, 1'b0, 1'b0, '0}
  };

  logic clk;
  logic rst;

  ihx_byte_if   byte_if ();
  ihx_result_if res_if ();

  ipv4_l4_header_extractor_top dut (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_if),
    .result_out (res_if)
  );

  // parser state mirror
  logic [15:0] pos_cnt   = '0;
  logic [15:0] etype_cap = '0;
  logic [3:0]  ihl_cap   = '0;
  logic [7:0]  proto_cap = '0;
  logic [31:0] sip_cap   = '0;
  logic [31:0] dip_cap   = '0;
  logic [15:0] sport_cap = '0;
  logic [15:0] dport_cap = '0;

  result_t    results_due [$];
  logic [7:0] frame_q [$];
  bit         use_typed;
  result_t    typed_want;
  int         send_idle_pct;
  int         stall_pct;
  int         mismatch_cnt;

  function automatic bit track_frame_byte(input logic [7:0] b, input logic last,
                                          output result_t res);
    int off;
    int len;
    res = '0;
    if (int'(pos_cnt) < MAX_BYTES) begin
      if (pos_cnt == POS_ETYPE_HI || pos_cnt == POS_ETYPE_LO) etype_cap = {etype_cap[7:0], b};
      if (pos_cnt == POS_IHL) ihl_cap = b[3:0];
      if (pos_cnt == POS_PROTO) proto_cap = b;
      if (pos_cnt >= POS_SRC_LO && pos_cnt <= POS_SRC_HI) sip_cap = {sip_cap[23:0], b};
      if (pos_cnt >= POS_DST_LO && pos_cnt <= POS_DST_HI) dip_cap = {dip_cap[23:0], b};
      // port offset sees the header length of the byte now arriving
      off = int'(ETH_HDR_BYTES) + 4 * int'(ihl_cap);
      if (int'(pos_cnt) == off || int'(pos_cnt) == off + 1) sport_cap = {sport_cap[7:0], b};
      if (int'(pos_cnt) == off + 2 || int'(pos_cnt) == off + 3) dport_cap = {dport_cap[7:0], b};
      pos_cnt++;
    end
    if (!last) return 1'b0;
    len = int'(pos_cnt);
    off = int'(ETH_HDR_BYTES) + 4 * int'(ihl_cap);
    res.frame_length = pos_cnt;
    if (etype_cap == ETHERTYPE_IPV4 && pos_cnt >= MIN_IPV4_FRAME) begin
      res.addr_valid = 1'b1;
      res.src_ip     = sip_cap;
      res.dst_ip     = dip_cap;
      if (proto_cap == PROTO_TCP && len >= off + int'(TCP_HDR_BYTES)) begin
        res.proto_kind = KIND_TCP;
        res.src_port   = sport_cap;
        res.dst_port   = dport_cap;
      end else if (proto_cap == PROTO_UDP && len >= off + int'(UDP_HDR_BYTES)) begin
        res.proto_kind = KIND_UDP;
        res.src_port   = sport_cap;
        res.dst_port   = dport_cap;
      end else if (proto_cap == PROTO_ICMP) begin
        res.proto_kind = KIND_ICMP;
      end
    end
    pos_cnt   = '0;
    etype_cap = '0;
    ihl_cap   = '0;
    proto_cap = '0;
    sip_cap   = '0;
    dip_cap   = '0;
    sport_cap = '0;
    dport_cap = '0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_cnt++;
    if (mismatch_cnt <= 40)
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic build_frame(input int len, input logic [15:0] etype, input logic [7:0] ihl_b,
                             input logic [7:0] proto, input logic [7:0] fill, input bit rnd);
    logic [7:0] b;
    frame_q.delete();
    for (int i = 0; i < len; i++) begin
      b = rnd ? 8'($urandom) : fill;
      case (16'(i))
        POS_ETYPE_HI: b = etype[15:8];
        POS_ETYPE_LO: b = etype[7:0];
        POS_IHL:      b = ihl_b;
        POS_PROTO:    b = proto;
        default: ;
      endcase
      frame_q = {frame_q, b};
    end
  endtask

  task automatic make_random_frame();
    int roll;
    int nib;
    int need;
    int len;
    logic [15:0] etype;
    logic [7:0] ihl_b;
    logic [7:0] proto;
    roll  = $urandom_range(0, 99);
    etype = 16'($urandom);
    ihl_b = 8'($urandom);
    proto = 8'($urandom);
    len   = $urandom_range(1, 40);
    if (roll < 70) begin
      nib = ($urandom_range(0, 1) == 0) ? 5 : $urandom_range(0, 15);
      ihl_b = {(($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'h4), 4'(nib)};
      case ($urandom_range(0, 3))
        0: proto = PROTO_TCP;
        1: proto = PROTO_UDP;
        2: proto = PROTO_ICMP;
        default: ;
      endcase
      etype = ETHERTYPE_IPV4;
      need = int'(ETH_HDR_BYTES) + 4 * nib;
      if (proto == PROTO_TCP) need += int'(TCP_HDR_BYTES);
      else if (proto == PROTO_UDP) need += int'(UDP_HDR_BYTES);
      if (need < int'(MIN_IPV4_FRAME)) need = int'(MIN_IPV4_FRAME);
      len = need - 4 + $urandom_range(0, 16);
    end else if (roll < 80) begin
      len = $urandom_range(1, 80);
    end else if (roll < 90) begin
      etype = ETHERTYPE_IPV4;
    end
    build_frame(len, etype, ihl_b, proto, 8'h00, 1'b1);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) begin
      while (send_idle_pct > 0 && $urandom_range(1, 100) <= send_idle_pct) begin
        byte_if.valid <= 1'b0;
        @(negedge clk);
      end
      byte_if.valid      <= 1'b1;
      byte_if.frame_byte <= frame_q[i];
      byte_if.last_byte  <= (i == frame_q.size() - 1);
      @(posedge clk);
      while (!byte_if.ready) @(posedge clk);
      @(negedge clk);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) res_if.ready <= ($urandom_range(1, 100) > stall_pct);

  always @(posedge clk) begin
    result_t pred;
    result_t w;
    if (!rst) begin
      if (byte_if.valid && byte_if.ready) begin
        if (track_frame_byte(byte_if.frame_byte, byte_if.last_byte, pred))
          results_due = {results_due, (use_typed ? typed_want : pred)};
      end
      if (res_if.valid && res_if.ready) begin
        if (results_due.size() == 0) begin
          report_mismatch("unexpected result", 32'(res_if.frame_length), 32'h0);
        end else begin
          w = results_due.pop_front();
          check_field("proto_kind", 32'(res_if.proto_kind), 32'(w.proto_kind));
          check_field("addr_valid", 32'(res_if.addr_valid), 32'(w.addr_valid));
          check_field("src_ip", res_if.src_ip, w.src_ip);
          check_field("dst_ip", res_if.dst_ip, w.dst_ip);
          check_field("src_port", 32'(res_if.src_port), 32'(w.src_port));
          check_field("dst_port", 32'(res_if.dst_port), 32'(w.dst_port));
          check_field("frame_length", 32'(res_if.frame_length), 32'(w.frame_length));
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int sent_bytes;
    int sent_frames;
    rst                = 1'b1;
    byte_if.valid      = 1'b0;
    byte_if.frame_byte = 8'h00;
    byte_if.last_byte  = 1'b0;
    res_if.ready       = 1'b1;
    send_idle_pct      = 0;
    stall_pct          = 0;
    mismatch_cnt       = 0;
    use_typed          = 1'b0;
    typed_want         = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < $size(dir_rows); r++) begin
      build_frame(int'(dir_rows[r].len), dir_rows[r].etype, dir_rows[r].ihl_b,
                  dir_rows[r].proto, dir_rows[r].fill, dir_rows[r].rnd);
      use_typed  = dir_rows[r].typed;
      typed_want = dir_rows[r].want;
      send_frame();
    end
    use_typed = 1'b0;

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 63; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 63; end
        default: begin send_idle_pct = 23; stall_pct = 23; end
      endcase
      sent_bytes  = 0;
      sent_frames = 0;
      while (sent_bytes < 375 || sent_frames < 12) begin
        make_random_frame();
        send_frame();
        sent_bytes += frame_q.size();
        sent_frames++;
      end
    end

    byte_if.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
